// ----- src/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the peak detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check an expression at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// Check a consequent in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Check a consequent in the cycle after its antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- src/mapd_pkg.sv -----
// Package with the widths, reset values and register codes of the peak detector.
package mapd_pkg;

   // field widths
   localparam int MIC_W    = 10;
   localparam int TIME_W   = 32;
   localparam int GAIN_W   = 4;
   localparam int MARGIN_W = 14;
   localparam int MS_W     = 16;
   localparam int SCALED_W = 14;
   localparam int AVG_W    = 14;
   localparam int RATE_W   = 8;
   localparam int CSR_W    = 16;

   // largest scaled sample: full-scale reading times the largest gain
   localparam int SCALED_MAX = 15345;

   // ring length default
   localparam int WINDOW_DEFAULT = 64;

   // register reset values
   localparam logic [GAIN_W-1:0]   GAIN_RESET    = 4'd10;
   localparam logic [MARGIN_W-1:0] MARGIN_RESET  = 14'd50;
   localparam logic [MS_W-1:0]     HOLDOFF_RESET = 16'd1;
   localparam logic [MS_W-1:0]     PERIOD_RESET  = 16'd100;

   // saturation point of the peak counter
   localparam logic [RATE_W-1:0] COUNT_MAX = 8'd255;

   // register indexes
   typedef enum logic [1:0] {
      CSR_SAMPLE_GAIN    = 2'd0,
      CSR_PEAK_MARGIN    = 2'd1,
      CSR_HOLDOFF_MS     = 2'd2,
      CSR_RATE_PERIOD_MS = 2'd3
   } csr_index_type;

endpackage

// ----- src/mapd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module mapd_ram #(
   parameter int DATA_W = 14,
   parameter int DEPTH  = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write one entry, read one entry into the output register
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/moving_average_peak_detector.sv -----
// Top level of the moving-average peak detector.
//
// Usage: each req_ word carries one 10-bit microphone reading and a 32-bit
// millisecond timestamp. Every accepted word gives exactly one rsp_ word: the
// truncated mean of the last WINDOW scaled samples (this one included), a peak
// flag and the peak count of the last completed rate period.
// Configuration is written through csr_write_enable / csr_index /
// csr_write_data while no word is in flight; writes take effect at once.
// A word accepted on req_ waits in the input register, then in the result
// register that drives rsp_. Throughput: one word per cycle while rsp_ready
// is high; the gain multiply sits before the input register, the running-sum
// update, average and peak compare sit between the input and result registers.
// The history ring is a RAM read one word ahead at the next write slot.
// Reset clears all control state and restores the register defaults. The
// ring needs no clearing pass: until the write slot has wrapped once, ring
// reads count as zero.
// When the receiver stalls, the result register holds its word and the input
// register takes one more; req_ready then drops until rsp_ready returns.
`include "assert_macros.svh"

module moving_average_peak_detector #(
   parameter int WINDOW = mapd_pkg::WINDOW_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // input channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [mapd_pkg::MIC_W-1:0]    req_mic_sample,
   input  logic [mapd_pkg::TIME_W-1:0]   req_time_ms,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mapd_pkg::AVG_W-1:0]    rsp_average_level,
   output logic                          rsp_peak_detected,
   output logic [mapd_pkg::RATE_W-1:0]   rsp_peak_rate,
   // configuration port
   input  logic                          csr_write_enable,
   input  logic [1:0]                    csr_index,
   input  logic [mapd_pkg::CSR_W-1:0]    csr_write_data
);

   localparam int IDX_W       = $clog2(WINDOW);
   localparam int SUM_W       = $clog2(mapd_pkg::SCALED_MAX * WINDOW + 1);
   localparam int RECIP_SHIFT = SUM_W + IDX_W;
   localparam int RECIP_W     = SUM_W + 2;
   localparam int PROD_W      = SUM_W + RECIP_W;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW - 1);

   // configuration registers
   logic [mapd_pkg::GAIN_W-1:0]   gain_ff;
   logic [mapd_pkg::MARGIN_W-1:0] margin_ff;
   logic [mapd_pkg::MS_W-1:0]     holdoff_ff;
   logic [mapd_pkg::MS_W-1:0]     period_ff;

   // input register
   logic                            s1_valid_ff;
   logic [mapd_pkg::SCALED_W-1:0]   s1_sample_ff;
   logic [mapd_pkg::TIME_W-1:0]     s1_time_ff;
   logic [mapd_pkg::SCALED_W-1:0]   scaled_in;

   // running state
   logic [IDX_W-1:0]                idx_ff, idx_in;
   logic                            filled_ff, filled_in;
   logic [SUM_W-1:0]                sum_ff, sum_in;
   logic [mapd_pkg::TIME_W-1:0]     last_peak_ff, last_peak_in;
   logic [mapd_pkg::TIME_W-1:0]     last_rate_ff, last_rate_in;
   logic [mapd_pkg::RATE_W-1:0]     count_ff, count_in;
   logic [mapd_pkg::RATE_W-1:0]     latched_ff, latched_in;

   // result register
   logic                            rsp_valid_ff;
   logic [mapd_pkg::AVG_W-1:0]      avg_ff;
   logic                            peak_ff;
   logic [mapd_pkg::RATE_W-1:0]     rate_ff;

   // datapath between the registers
   logic                            advance;
   logic                            accept;
   logic [mapd_pkg::SCALED_W-1:0]   ring_rd;
   logic [mapd_pkg::SCALED_W-1:0]   oldest;
   logic [mapd_pkg::AVG_W-1:0]      avg;
   logic                            rate_hit;
   logic [mapd_pkg::RATE_W-1:0]     count_mid;
   logic                            level_hit;
   logic                            time_hit;
   logic                            peak;
   logic [mapd_pkg::TIME_W-1:0]     since_peak;
   logic [mapd_pkg::TIME_W-1:0]     since_rate;
   logic [mapd_pkg::MARGIN_W:0]     threshold;

   // handshake: the input register moves on when the result register is free
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   // scale the reading on the way into the input register
   assign scaled_in = mapd_pkg::SCALED_W'(req_mic_sample) * mapd_pkg::SCALED_W'(gain_ff);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff    <= mapd_pkg::GAIN_RESET;
         margin_ff  <= mapd_pkg::MARGIN_RESET;
         holdoff_ff <= mapd_pkg::HOLDOFF_RESET;
         period_ff  <= mapd_pkg::PERIOD_RESET;
      end else if (csr_write_enable) begin
         case (mapd_pkg::csr_index_type'(csr_index))
            mapd_pkg::CSR_SAMPLE_GAIN: begin
               gain_ff <= csr_write_data[mapd_pkg::GAIN_W-1:0];
            end
            mapd_pkg::CSR_PEAK_MARGIN: begin
               margin_ff <= csr_write_data[mapd_pkg::MARGIN_W-1:0];
            end
            mapd_pkg::CSR_HOLDOFF_MS: begin
               holdoff_ff <= csr_write_data[mapd_pkg::MS_W-1:0];
            end
            mapd_pkg::CSR_RATE_PERIOD_MS: begin
               period_ff <= csr_write_data[mapd_pkg::MS_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
      if (accept) begin
         s1_sample_ff <= scaled_in;
         s1_time_ff   <= req_time_ms;
      end
   end

   // history ring, read one slot ahead of the write
   mapd_ram #(
      .DATA_W (mapd_pkg::SCALED_W),
      .DEPTH  (WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (advance),
      .wr_addr (idx_ff),
      .wr_data (s1_sample_ff),
      .rd_addr (idx_in),
      .rd_data (ring_rd)
   );

   // unwritten slots read as zero until the ring has wrapped once
   assign oldest = filled_ff ? ring_rd : '0;

   // advance the write slot and update the running sum
   always_comb begin
      idx_in    = idx_ff;
      filled_in = filled_ff;
      sum_in    = sum_ff;
      if (advance) begin
         idx_in    = (idx_ff == IDX_LAST) ? '0 : idx_ff + 1'b1;
         filled_in = filled_ff || (idx_ff == IDX_LAST);
         sum_in    = sum_ff + SUM_W'(s1_sample_ff) - SUM_W'(oldest);
      end
   end

   // divide the new sum by the ring length
   generate
      if ((WINDOW & (WINDOW - 1)) == 0) begin : g_shift_avg
         assign avg = mapd_pkg::AVG_W'(sum_in >> IDX_W);
      end else begin : g_recip_avg
         localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
            ((64'd1 << RECIP_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
         logic [PROD_W-1:0] prod;
         assign prod = PROD_W'(sum_in) * PROD_W'(RECIP);
         assign avg  = mapd_pkg::AVG_W'(prod >> RECIP_SHIFT);
      end
   endgenerate

   // rate period check, then peak check
   always_comb begin
      since_rate   = s1_time_ff - last_rate_ff;
      rate_hit     = since_rate >= mapd_pkg::TIME_W'(period_ff);
      count_mid    = rate_hit ? '0 : count_ff;
      latched_in   = latched_ff;
      last_rate_in = last_rate_ff;
      if (advance && rate_hit) begin
         latched_in   = count_ff;
         last_rate_in = s1_time_ff;
      end

      threshold    = (mapd_pkg::MARGIN_W + 1)'(avg) + (mapd_pkg::MARGIN_W + 1)'(margin_ff);
      level_hit    = (mapd_pkg::MARGIN_W + 1)'(s1_sample_ff) > threshold;
      since_peak   = s1_time_ff - last_peak_ff;
      time_hit     = since_peak > mapd_pkg::TIME_W'(holdoff_ff);
      peak         = level_hit && time_hit;

      count_in     = count_ff;
      last_peak_in = last_peak_ff;
      if (advance) begin
         count_in = count_mid;
         if (peak) begin
            last_peak_in = s1_time_ff;
            if (count_mid != mapd_pkg::COUNT_MAX) begin
               count_in = count_mid + 1'b1;
            end
         end
      end
   end

   // running state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         filled_ff    <= 1'b0;
         sum_ff       <= '0;
         last_peak_ff <= '0;
         last_rate_ff <= '0;
         count_ff     <= '0;
         latched_ff   <= '0;
      end else begin
         idx_ff       <= idx_in;
         filled_ff    <= filled_in;
         sum_ff       <= sum_in;
         last_peak_ff <= last_peak_in;
         last_rate_ff <= last_rate_in;
         count_ff     <= count_in;
         latched_ff   <= latched_in;
      end
   end

   // result register: load on advance, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         avg_ff  <= avg;
         peak_ff <= peak;
         rate_ff <= latched_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_average_level = avg_ff;
   assign rsp_peak_detected = peak_ff;
   assign rsp_peak_rate     = rate_ff;

   // checks
   `ASSERT_IMPLIES(a_avg_range, clock, reset, rsp_valid_ff,
                   avg_ff <= mapd_pkg::AVG_W'(mapd_pkg::SCALED_MAX),
                   "average above full scale")
   `ASSERT_ALWAYS(a_sum_range, clock, reset,
                  sum_ff <= SUM_W'(mapd_pkg::SCALED_MAX * WINDOW),
                  "running sum above ring capacity")
   `ASSERT_NEXT(a_peak_time, clock, reset, !reset && advance && peak,
                last_peak_ff == $past(s1_time_ff), "peak time not recorded")
   `ASSERT_NEXT(a_stage_hold, clock, reset, !reset && s1_valid_ff && !advance,
                s1_valid_ff && $stable(s1_sample_ff) && $stable(s1_time_ff),
                "input register lost a word")

endmodule

// ----- dv/moving_average_peak_detector_tb.sv -----
// Self-checking testbench for the moving-average peak detector: drives words, predicts, compares.
module moving_average_peak_detector_tb;

   localparam int WINDOW       = mapd_pkg::WINDOW_DEFAULT;
   localparam int LIMIT_CYCLES = 200000;
   localparam int HOLD_CYCLES  = 60;

   typedef struct packed {
      logic [mapd_pkg::AVG_W-1:0]  level;
      logic                        peak;
      logic [mapd_pkg::RATE_W-1:0] rate;
   } detector_word_type;

   typedef enum int {
      CONTENT_SPIKY,
      CONTENT_UNIFORM,
      CONTENT_DENSE
   } content_style_type;

   // Track the detector state and hold the result words still owed by the block
   class peak_tracker;
      logic [mapd_pkg::GAIN_W-1:0]   gain;
      logic [mapd_pkg::MARGIN_W-1:0] margin;
      logic [mapd_pkg::MS_W-1:0]     holdoff;
      logic [mapd_pkg::MS_W-1:0]     period;
      logic [mapd_pkg::SCALED_W-1:0] ring [WINDOW];
      int unsigned                   slot;
      logic [19:0]                   sum;
      logic [mapd_pkg::TIME_W-1:0]   last_peak_ms;
      logic [mapd_pkg::TIME_W-1:0]   last_rate_ms;
      logic [mapd_pkg::RATE_W-1:0]   peak_count;
      logic [mapd_pkg::RATE_W-1:0]   rate_latch;
      detector_word_type             pending_words [$];
      int unsigned                   mismatches;
      int unsigned                   checked;

      function new();
         gain         = mapd_pkg::GAIN_RESET;
         margin       = mapd_pkg::MARGIN_RESET;
         holdoff      = mapd_pkg::HOLDOFF_RESET;
         period       = mapd_pkg::PERIOD_RESET;
         foreach (ring[i]) ring[i] = '0;
         slot         = 0;
         sum          = '0;
         last_peak_ms = '0;
         last_rate_ms = '0;
         peak_count   = '0;
         rate_latch   = '0;
         mismatches   = 0;
         checked      = 0;
      endfunction

      function void set_register(mapd_pkg::csr_index_type idx,
                                 logic [mapd_pkg::CSR_W-1:0] data);
         case (idx)
            mapd_pkg::CSR_SAMPLE_GAIN:    gain    = data[mapd_pkg::GAIN_W-1:0];
            mapd_pkg::CSR_PEAK_MARGIN:    margin  = data[mapd_pkg::MARGIN_W-1:0];
            mapd_pkg::CSR_HOLDOFF_MS:     holdoff = data[mapd_pkg::MS_W-1:0];
            mapd_pkg::CSR_RATE_PERIOD_MS: period  = data[mapd_pkg::MS_W-1:0];
            default: ;
         endcase
      endfunction

      // Advance the state by one accepted input word and queue its result
      function void note_sample(logic [mapd_pkg::MIC_W-1:0] mic,
                                logic [mapd_pkg::TIME_W-1:0] now_ms);
         logic [mapd_pkg::SCALED_W-1:0] scaled;
         logic [31:0]                   avg;
         logic [mapd_pkg::TIME_W-1:0]   since_rate;
         logic [mapd_pkg::TIME_W-1:0]   since_peak;
         detector_word_type             word;

         // latch the count once the rate period has run out, wrap included
         since_rate = now_ms - last_rate_ms;
         if (since_rate >= 32'(period)) begin
            rate_latch   = peak_count;
            peak_count   = '0;
            last_rate_ms = now_ms;
         end

         // replace the oldest ring entry and refresh the sum
         scaled     = mapd_pkg::SCALED_W'(mic * gain);
         sum        = sum + 20'(scaled) - 20'(ring[slot]);
         avg        = 32'(sum) / WINDOW;
         ring[slot] = scaled;
         slot       = (slot + 1) % WINDOW;

         since_peak = now_ms - last_peak_ms;
         word.peak  = (32'(scaled) > avg + 32'(margin)) && (since_peak > 32'(holdoff));
         if (word.peak) begin
            if (peak_count != mapd_pkg::COUNT_MAX) peak_count++;
            last_peak_ms = now_ms;
         end

         word.level = avg[mapd_pkg::AVG_W-1:0];
         word.rate  = rate_latch;
         pending_words.push_back(word);
      endfunction

      // Compare one result word with the oldest expectation
      function void check_word(detector_word_type got);
         detector_word_type want;
         checked++;
         if (pending_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result word with none expected: level %0d peak %0d rate %0d",
                        $realtime, got.level, got.peak, got.rate);
            return;
         end
         want = pending_words.pop_front();
         if (got.level !== want.level || got.peak !== want.peak || got.rate !== want.rate) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: word %0d level %0d/%0d peak %0d/%0d rate %0d/%0d (exp/act)",
                        $realtime, checked, want.level, got.level, want.peak, got.peak,
                        want.rate, got.rate);
         end
      endfunction
   endclass

   logic                           clock            = 1'b0;
   logic                           reset            = 1'b1;
   logic                           req_valid        = 1'b0;
   logic                           req_ready;
   logic [mapd_pkg::MIC_W-1:0]     req_mic_sample   = '0;
   logic [mapd_pkg::TIME_W-1:0]    req_time_ms      = '0;
   logic                           rsp_valid;
   logic                           rsp_ready        = 1'b0;
   logic [mapd_pkg::AVG_W-1:0]     rsp_average_level;
   logic                           rsp_peak_detected;
   logic [mapd_pkg::RATE_W-1:0]    rsp_peak_rate;
   logic                           csr_write_enable = 1'b0;
   logic [1:0]                     csr_index        = '0;
   logic [mapd_pkg::CSR_W-1:0]     csr_write_data   = '0;

   peak_tracker                    tracker = new();
   bit                             quiet       = 1'b0;
   bit                             sender_gaps = 1'b0;
   bit                             sink_bursts = 1'b1;
   logic [mapd_pkg::TIME_W-1:0]    stamp_ms    = '0;

   moving_average_peak_detector u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mic_sample    (req_mic_sample),
      .req_time_ms       (req_time_ms),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_average_level (rsp_average_level),
      .rsp_peak_detected (rsp_peak_detected),
      .rsp_peak_rate     (rsp_peak_rate),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always #5 clock = ~clock;

   // Sample both handshakes; drain results before noting the new word
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            tracker.check_word('{rsp_average_level, rsp_peak_detected, rsp_peak_rate});
         if (req_valid && req_ready)
            tracker.note_sample(req_mic_sample, req_time_ms);
      end
   end

   // Drive rsp_ready: short random stalls, plus one long hold-off to back up the block
   initial begin
      int unsigned stall_left;
      bit          hold_done;
      stall_left = 0;
      hold_done  = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && tracker.checked >= 150) begin
            hold_done  = 1'b1;
            stall_left = HOLD_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else if (sink_bursts && !quiet && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Offer one word and hold it until accepted
   task automatic send_sample(input logic [mapd_pkg::MIC_W-1:0] mic,
                              input logic [mapd_pkg::TIME_W-1:0] now_ms);
      req_valid      <= 1'b1;
      req_mic_sample <= mic;
      req_time_ms    <= now_ms;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (sender_gaps && !quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every owed result word has come back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_words.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_register(input mapd_pkg::csr_index_type idx,
                                 input logic [mapd_pkg::CSR_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      tracker.set_register(idx, data);
   endtask

   task automatic apply_settings(input logic [mapd_pkg::GAIN_W-1:0]   gain,
                                 input logic [mapd_pkg::MARGIN_W-1:0] margin,
                                 input logic [mapd_pkg::MS_W-1:0]     holdoff,
                                 input logic [mapd_pkg::MS_W-1:0]     period);
      write_register(mapd_pkg::CSR_SAMPLE_GAIN, mapd_pkg::CSR_W'(gain));
      write_register(mapd_pkg::CSR_PEAK_MARGIN, mapd_pkg::CSR_W'(margin));
      write_register(mapd_pkg::CSR_HOLDOFF_MS, holdoff);
      write_register(mapd_pkg::CSR_RATE_PERIOD_MS, period);
      csr_write_enable <= 1'b0;
   endtask

   // Pick a register setting with the extremes well represented
   task automatic random_settings();
      logic [mapd_pkg::GAIN_W-1:0]   gain;
      logic [mapd_pkg::MARGIN_W-1:0] margin;
      logic [mapd_pkg::MS_W-1:0]     holdoff;
      logic [mapd_pkg::MS_W-1:0]     period;
      gain = mapd_pkg::GAIN_W'($urandom_range(0, 15));
      case ($urandom_range(0, 3))
         0:       margin = '0;
         1:       margin = '1;
         default: margin = mapd_pkg::MARGIN_W'($urandom_range(0, 3000));
      endcase
      case ($urandom_range(0, 3))
         0:       holdoff = '0;
         1:       holdoff = '1;
         default: holdoff = mapd_pkg::MS_W'($urandom_range(0, 10));
      endcase
      case ($urandom_range(0, 4))
         0:       period = '0;
         1:       period = 16'd1;
         2:       period = '1;
         default: period = mapd_pkg::MS_W'($urandom_range(2, 300));
      endcase
      apply_settings(gain, margin, holdoff, period);
   endtask

   // Send a run of words; time mostly creeps forward, with rare jumps anywhere
   task automatic run_phase(input int unsigned count, input content_style_type style);
      logic [mapd_pkg::MIC_W-1:0] mic;
      for (int unsigned n = 0; n < count; n++) begin
         case (style)
            CONTENT_DENSE:
               mic = ($urandom_range(0, 7) == 0) ? '0
                                                 : mapd_pkg::MIC_W'($urandom_range(900, 1023));
            CONTENT_SPIKY:
               mic = ($urandom_range(0, 5) == 0) ? mapd_pkg::MIC_W'($urandom_range(600, 1023))
                                                 : mapd_pkg::MIC_W'($urandom_range(0, 200));
            default:
               mic = mapd_pkg::MIC_W'($urandom_range(0, 1023));
         endcase
         if (style == CONTENT_DENSE)
            stamp_ms = stamp_ms + 1;
         else if ($urandom_range(0, 39) == 0)
            stamp_ms = $urandom();
         else
            stamp_ms = stamp_ms + $urandom_range(0, 4);
         send_sample(mic, stamp_ms);
      end
   endtask

   initial begin
      int unsigned random_items;
      random_items = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: holdoff boundary, rate latch, timestamp wrap, bit extremes
      send_sample(10'd0, 32'd0);
      send_sample(10'd1023, 32'd0);
      send_sample(10'd1023, 32'd1);
      send_sample(10'd1023, 32'd2);
      send_sample(10'd1023, 32'd3);
      send_sample(10'd1023, 32'd100);
      send_sample(10'd0, 32'hFFFF_FFFE);
      send_sample(10'd1023, 32'hFFFF_FFFF);
      send_sample(10'd1023, 32'h0000_0001);
      send_sample(10'h155, 32'h5555_5555);
      send_sample(10'h2AA, 32'hAAAA_AAAA);
      settle();

      // zero gain and zero period: every word latches the rate
      apply_settings('0, mapd_pkg::MARGIN_RESET, mapd_pkg::HOLDOFF_RESET, '0);
      send_sample(10'd1023, 32'd5);
      send_sample(10'd1023, 32'd6);
      send_sample(10'd0, 32'd7);
      send_sample(10'd1023, 32'd8);
      settle();

      // largest gain, margin, holdoff and period
      apply_settings('1, '1, '1, '1);
      send_sample(10'd1023, 32'd10);
      send_sample(10'd1023, 32'd70000);
      send_sample(10'd0, 32'd70001);
      send_sample(10'd1023, 32'd140000);
      settle();

      // dense peaks in one long period to saturate the counter, then latch it
      apply_settings('1, '0, '0, '1);
      sender_gaps = 1'b0;
      stamp_ms    = 32'd1000;
      run_phase(300, CONTENT_DENSE);
      stamp_ms = stamp_ms + 70000;
      send_sample(10'd512, stamp_ms);
      random_items = 301;
      settle();

      // random settings and content, with idling turned on and off per phase
      while (random_items < 620) begin
         int unsigned       count;
         content_style_type style;
         count       = $urandom_range(60, 120);
         style       = ($urandom_range(0, 2) == 0) ? CONTENT_UNIFORM : CONTENT_SPIKY;
         sender_gaps = $urandom_range(0, 2) != 0;
         sink_bursts = $urandom_range(0, 2) != 0;
         case ($urandom_range(0, 2))
            0:       stamp_ms = $urandom();
            1:       stamp_ms = 32'hFFFF_FFFF - $urandom_range(0, 200);
            default: ;
         endcase
         random_settings();
         run_phase(count, style);
         random_items += count;
         settle();
      end

      // last stretch at full rate on both sides
      quiet = 1'b1;
      random_settings();
      run_phase(100, CONTENT_SPIKY);
      settle();

      if (tracker.mismatches == 0 && tracker.pending_words.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Bound the run in case the block hangs
   initial begin
      #(LIMIT_CYCLES * 10);
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+src
src/mapd_pkg.sv
src/mapd_ram.sv
src/moving_average_peak_detector.sv
dv/moving_average_peak_detector_tb.sv
